// File: sv/pts_pkg.sv
// types and constants shared by the priority task scheduler
// no dependencies
`timescale 1ns / 1ps

package pts_pkg;

  localparam int PID_BITS = 16;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_YIELD  = 3'd1;
  localparam logic [2:0] OP_CREATE = 3'd2;
  localparam logic [2:0] OP_EXIT   = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  localparam logic [1:0] RS_READY   = 2'd0;
  localparam logic [1:0] RS_RUNNING = 2'd1;
  localparam logic [1:0] RS_ZOMBIE  = 2'd2;

  localparam logic [7:0] QUANTUM_RESET = 8'd10;
  localparam logic [6:0] IDLE_PRIO_RESET = 7'd99;

  localparam int REG_QUANTUM = 0;
  localparam int REG_IDLE_PRIO = 1;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  new_priority;
    logic [7:0]  exit_status;
    logic [15:0] target_pid;
  } pts_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] current_pid;
    logic [15:0] previous_pid;
    logic        switched;
    logic [15:0] created_pid;
    logic [15:0] notify_parent_pid;
  } pts_rsp_t;

endpackage

// File: sv/priority_task_scheduler_core.sv
// top level of the priority task scheduler: slot table memory and sequencer
// depends on pts_pkg
`timescale 1ns / 1ps

// Fixed-priority task scheduler. Each request (tick, yield, create, exit,
// remove) gives one response. The slot table lives in one synchronous memory
// with one read port and one write port. A request that reschedules (yield,
// exit, a tick that ends the quantum) scans the whole table, one slot read
// per cycle; create and remove scan it too and then write a slot if one is
// found and the request is not refused; any other request skips the scan.
// After reset a clearing pass writes every slot before the first request is
// taken. A finished response waits in an output register and holds off the
// next request, which is taken at the earliest in the cycle after the
// response is.
module priority_task_scheduler_core #(
  parameter int TASK_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pts_pkg::pts_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pts_pkg::pts_rsp_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import pts_pkg::*;

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);

  // one slot entry
  typedef struct packed {
    logic                used;
    logic [1:0]          rs;
    logic [PID_BITS-1:0] pid;
    logic [PID_BITS-1:0] parent;
    logic [6:0]          prio;
    logic [7:0]          qleft;
    logic [7:0]          exitv;
    logic [31:0]         ticks;
  } slot_t;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RDCUR  = 4'd2;
  localparam logic [3:0] S_CUR    = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SCEND  = 4'd5;
  localparam logic [3:0] S_RDNXT  = 4'd6;
  localparam logic [3:0] S_NXT    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_RSCAN  = 4'd9;
  localparam logic [3:0] S_CREND  = 4'd10;
  localparam logic [3:0] S_CRWR   = 4'd11;

  slot_t mem [TASK_SLOTS];
  slot_t rd_data;
  logic [SW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  slot_t         wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  logic [3:0]          state;
  logic [7:0]          quantum_ticks;
  logic [6:0]          idle_priority;
  logic [SW-1:0]       running_slot;
  logic [PID_BITS-1:0] pid_counter;
  logic [PID_BITS-1:0] running_pid;   // copy of the running slot's pid
  pts_req_t            req;
  slot_t               cur;           // running slot after first update
  slot_t               cur_next;
  logic [CW-1:0]       cnt;           // scan counter, read address
  logic [SW-1:0]       scan_slot;     // slot whose data is in rd_data
  logic                scan_vld;
  logic                found;
  logic [SW-1:0]       best;
  logic [6:0]          best_prio;
  logic [PID_BITS-1:0] best_pid;
  logic                resched;
  logic [1:0]          status;
  logic [PID_BITS-1:0] prev_pid;
  logic [SW-1:0]       prev_slot;
  logic [PID_BITS-1:0] created;
  logic [PID_BITS-1:0] notify;

  // apb; the user must write the registers only while idle, the block itself does not enforce it
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      1'b0:    prdata = {24'd0, quantum_ticks};
      default: prdata = {25'd0, idle_priority};
    endcase
  end

  assign in_stall = (state != S_IDLE) || out_valid;

  logic accept;
  assign accept = in_valid && !in_stall;

  // comparison of the candidate in rd_data with the best so far
  logic cand_ok, cand_better;
  assign cand_ok = scan_vld && rd_data.used && (rd_data.rs == RS_READY);
  assign cand_better = !found || (rd_data.prio < best_prio) ||
                       ((rd_data.prio == best_prio) && (rd_data.pid < best_pid));

  // remove: slot matches the target pid
  logic rm_hit;
  assign rm_hit = scan_vld && rd_data.used &&
                  (rd_data.pid == PID_BITS'(req.target_pid));

  logic [PID_BITS-1:0] pid_inc;
  assign pid_inc = pid_counter + 1'b1;

  // running slot as updated by the event, before any reschedule
  always_comb begin
    cur_next = rd_data;
    if (running_slot == '0) cur_next.prio = idle_priority;
    case (req.op)
      OP_TICK: begin
        cur_next.ticks = rd_data.ticks + 32'd1;
        if (rd_data.qleft != 8'd0) cur_next.qleft = rd_data.qleft - 8'd1;
        if ((rd_data.qleft <= 8'd1) && (rd_data.rs == RS_RUNNING)) cur_next.rs = RS_READY;
      end
      OP_YIELD: begin
        if (rd_data.rs == RS_RUNNING) cur_next.rs = RS_READY;
      end
      OP_EXIT: begin
        cur_next.rs = RS_ZOMBIE;
        cur_next.exitv = req.exit_status;
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = cnt[SW-1:0];
    wr_en = 1'b0;
    wr_addr = cnt[SW-1:0];
    wr_data = '0;
    unique case (state) inside
      S_CLEAR: begin
        wr_en = 1'b1;
        if (cnt == '0) begin
          wr_data.used = 1'b1;
          wr_data.pid = PID_BITS'(1);
          wr_data.prio = idle_priority;
          wr_data.qleft = quantum_ticks;
        end
      end
      S_IDLE: begin
        rd_en = accept;
        rd_addr = running_slot;
        // an idle priority write does not touch slot 0 in memory; a read-modify-write
        // is avoided by taking slot 0 priority from idle_priority (see below)
      end
      S_RDCUR: ;
      S_CUR: ;
      S_SCAN, S_RSCAN: begin
        rd_en = (cnt < CW'(TASK_SLOTS));
        // write back the running slot once, at the start of a reschedule
        if (state == S_SCAN && cnt == '0) begin
          wr_en = 1'b1;
          wr_addr = running_slot;
          wr_data = cur;
        end
      end
      S_SCEND: ;
      S_RDNXT: begin
        rd_en = 1'b1;
        rd_addr = best;
      end
      S_NXT: begin
        wr_en = 1'b1;
        wr_addr = best;
        wr_data = rd_data;
        if (best == running_slot) wr_data = cur;
        wr_data.rs = RS_RUNNING;
        if (best != running_slot) wr_data.qleft = quantum_ticks;
        if (best == '0) wr_data.prio = idle_priority;
      end
      S_CREND: ;
      S_CRWR: begin
        wr_en = 1'b1;
        wr_addr = best;
        wr_data.used = 1'b1;
        wr_data.pid = created;
        wr_data.parent = running_pid;
        wr_data.prio = req.new_priority;
        wr_data.qleft = quantum_ticks;
        if (req.op == OP_REMOVE) wr_data = '0;
      end
      S_DONE: begin
        if (!resched && (req.op == OP_TICK)) begin
          wr_en = 1'b1;
          wr_addr = running_slot;
          wr_data = cur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      quantum_ticks <= QUANTUM_RESET;
      idle_priority <= IDLE_PRIO_RESET;
      running_slot <= '0;
      running_pid <= PID_BITS'(1);
      pid_counter <= PID_BITS'(2);
      out_valid <= 1'b0;
      scan_vld <= 1'b0;
      found <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == 1'b0) quantum_ticks <= pwdata[7:0];
        else idle_priority <= pwdata[6:0];
      end
      scan_vld <= rd_en && (state == S_SCAN || state == S_RSCAN);
      scan_slot <= cnt[SW-1:0];
      unique case (state)
        S_CLEAR: begin
          if (cnt[SW-1:0] == LAST_SLOT) begin
            cnt <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req <= in_data;
            prev_slot <= running_slot;
            prev_pid <= running_pid;
            status <= ST_OK;
            created <= '0;
            notify <= '0;
            resched <= 1'b0;
            state <= S_RDCUR;
          end
        end
        S_RDCUR: state <= S_CUR;
        S_CUR: begin
          cur <= cur_next;
          cnt <= '0;
          found <= 1'b0;
          unique case (req.op) inside
            OP_TICK: begin
              if (rd_data.qleft <= 8'd1) begin
                resched <= 1'b1;
                state <= S_SCAN;
              end else begin
                state <= S_DONE;
              end
            end
            OP_YIELD: begin
              resched <= 1'b1;
              state <= S_SCAN;
            end
            OP_EXIT: begin
              resched <= 1'b1;
              notify <= rd_data.parent;
              state <= S_SCAN;
            end
            OP_CREATE, OP_REMOVE: state <= S_RSCAN;
            default: state <= S_DONE;
          endcase
        end
        S_SCAN: begin
          // forward the written-back running slot
          if (cnt < CW'(TASK_SLOTS)) cnt <= cnt + 1'b1;
          if (cand_ok || (scan_vld && scan_slot == running_slot &&
                          cur.used && cur.rs == RS_READY)) begin
            if (scan_slot == running_slot) begin
              if (!found || (cur.prio < best_prio) ||
                  ((cur.prio == best_prio) && (cur.pid < best_pid))) begin
                if (cur.used && cur.rs == RS_READY) begin
                  found <= 1'b1; best <= scan_slot;
                  best_prio <= cur.prio; best_pid <= cur.pid;
                end
              end
            end else if (cand_better) begin
              found <= 1'b1; best <= scan_slot;
              best_prio <= (scan_slot == '0) ? idle_priority : rd_data.prio;
              best_pid <= rd_data.pid;
            end
          end
          if (scan_vld && scan_slot == LAST_SLOT) state <= S_SCEND;
        end
        S_SCEND: begin
          if (!found) best <= '0;
          state <= S_RDNXT;
        end
        S_RDNXT: state <= S_NXT;
        S_NXT: begin
          running_slot <= best;
          running_pid <= (best == running_slot) ? cur.pid : rd_data.pid;
          state <= S_DONE;
        end
        S_RSCAN: begin
          if (cnt < CW'(TASK_SLOTS)) cnt <= cnt + 1'b1;
          if (scan_vld && !found) begin
            if (req.op == OP_CREATE && !rd_data.used) begin
              found <= 1'b1; best <= scan_slot;
            end
            if (req.op == OP_REMOVE && rm_hit) begin
              found <= 1'b1; best <= scan_slot;
            end
          end
          if (scan_vld && scan_slot == LAST_SLOT) state <= S_CREND;
        end
        S_CREND: begin
          if (req.op == OP_CREATE) begin
            if (!found) begin
              status <= ST_FULL;
              state <= S_DONE;
            end else begin
              created <= pid_counter;
              pid_counter <= (pid_inc == '0) ? PID_BITS'(1) : pid_inc;
              state <= S_CRWR;
            end
          end else begin
            if (!found) begin
              status <= ST_NOTFND;
              state <= S_DONE;
            end else if (best == '0 || best == running_slot) begin
              status <= ST_REFUSED;
              state <= S_DONE;
            end else begin
              state <= S_CRWR;
            end
          end
        end
        S_CRWR: state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          out_data.status <= status;
          out_data.current_pid <= 16'(running_pid);
          out_data.previous_pid <= 16'(prev_pid);
          out_data.switched <= (running_slot != prev_slot);
          out_data.created_pid <= 16'(created);
          out_data.notify_parent_pid <= 16'(notify);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a response is only raised from the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("stray response");
  // no request accepted while a response waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !accept) else $error("request taken while response pending");
  // a switch only follows a reschedule
  a_switch_resched: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && running_slot != prev_slot) |-> resched)
    else $error("switch without reschedule");

endmodule
